// File: rtl/pbc_pkg.sv
// shared constants, register codes and the per-channel datapath function
// for the pixel brightness/contrast unit; no dependencies
package pbc_pkg;

  localparam int PIX_W     = 32;
  localparam int CHAN_W    = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;

  // gain is unsigned Q2.16
  localparam int GAIN_W    = 18;
  localparam int FRAC_W    = 16;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << FRAC_W);

  // divider operand widths: numerator 259*(c+255) << 16, denominator 255*(259-c)
  localparam int NUM_W     = 33;
  localparam int DEN_W     = 17;
  localparam int CNT_W     = $clog2(NUM_W + 1);

  localparam int K_259     = 259;
  localparam int K_255     = 255;

  localparam logic signed [CHAN_W+1:0]  CHAN_MAX_S = 10'sd255;
  localparam logic signed [CHAN_W:0]    CHAN_MID_S = 9'sd128;
  localparam logic signed [11:0]        Q_MID      = 12'sd128;
  localparam logic signed [11:0]        Q_MAX      = 12'sd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_CONTRAST   = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } gdiv_stat_t;

  // brightness add and clamp, then floor((b-128)*gain)+128 and clamp
  function automatic logic [CHAN_W-1:0] adj_chan(
    input logic        [CHAN_W-1:0] ch,
    input logic signed [CFG_W-1:0]  off,
    input logic        [GAIN_W-1:0] gain
  );
    logic signed [CHAN_W+1:0]  s;
    logic        [CHAN_W-1:0]  b;
    logic signed [CHAN_W:0]    d;
    logic signed [GAIN_W:0]    g;
    logic signed [27:0]        p;
    logic signed [11:0]        q;
    logic signed [11:0]        v;
    logic        [CHAN_W-1:0]  res;
    s = $signed({2'b00, ch}) + $signed({{2{off[CFG_W-1]}}, off});
    if (s < 0) begin
      b = '0;
    end else if (s > CHAN_MAX_S) begin
      b = '1;
    end else begin
      b = s[CHAN_W-1:0];
    end
    d = $signed({1'b0, b}) - CHAN_MID_S;
    g = $signed({1'b0, gain});
    p = 28'(d) * 28'(g);
    // arithmetic shift floors toward minus infinity
    q = 12'(p >>> FRAC_W);
    v = q + Q_MID;
    if (v < 0) begin
      res = '0;
    end else if (v > Q_MAX) begin
      res = '1;
    end else begin
      res = v[CHAN_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/pbc_gain_div.sv
// contrast gain unit: restoring long division, one quotient bit per cycle
// depends on pbc_pkg
module pbc_gain_div
  import pbc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [CFG_W-1:0]  level,
  output gdiv_stat_t               stat,
  output logic        [GAIN_W-1:0] gain
);

  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [9:0]       lv_plus;   // c + 255, 127..382
  logic [9:0]       lv_minus;  // 259 - c, 132..387
  logic [DEN_W-1:0] num_base;
  logic [DEN_W:0]   rem_sh;
  logic             qbit;
  logic             busy;

  assign lv_plus  = 10'($signed({{2{level[CFG_W-1]}}, level}) + 10'sd255);
  assign lv_minus = 10'(10'sd259 - $signed({{2{level[CFG_W-1]}}, level}));
  assign num_base = DEN_W'(lv_plus) * DEN_W'(K_259);

  assign busy   = (cnt_r != '0);
  assign rem_sh = {rem_r[DEN_W-1:0], num_r[NUM_W-1]};
  assign qbit   = (rem_sh >= {1'b0, den_r});

  always_comb begin
    num_nxt = num_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (start) begin
      num_nxt = {num_base, {FRAC_W{1'b0}}};
      den_nxt = DEN_W'(lv_minus) * DEN_W'(K_255);
      rem_nxt = '0;
      cnt_nxt = CNT_W'(NUM_W);
    end else if (busy) begin
      num_nxt = {num_r[NUM_W-2:0], qbit};
      rem_nxt = qbit ? (rem_sh - {1'b0, den_r}) : rem_sh;
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy;
  assign stat.done = busy && (cnt_r == CNT_W'(1)) && !start;
  assign gain      = num_nxt[GAIN_W-1:0];

endmodule

// File: rtl/pixel_brightness_contrast_unit.sv
// top level of the pixel brightness/contrast unit: config registers,
// input register, per-channel datapath and result register
// depends on pbc_pkg and pbc_gain_div
//
// channel   dir   fields (lsb first)      notes
// in_*      in    tdata: pixel_in[31:0]   argb source pixel
// out_*     out   tdata: pixel_out[31:0]  argb adjusted pixel, alpha unchanged
// cfg_*     in    index 0 brightness, 1 contrast, 8-bit signed data
//
// one pixel per clock sustained while out_tready is high and no gain divide runs;
// input register, then the whole channel datapath, then result register
// a contrast write runs the gain divider (one quotient bit a cycle);
// in_tready is low during that time
// after reset gain is unity and brightness zero; no clearing pass
// a stalled result holds in the output register while one more item waits
// in the input register
module pixel_brightness_contrast_unit
  import pbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [PIX_W-1:0]     in_tdata,   // pixel_in[31:0]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [PIX_W-1:0]     out_tdata,  // pixel_out[31:0]
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // configuration and derived gain
  logic signed [CFG_W-1:0]  bright_r, bright_nxt;
  logic        [GAIN_W-1:0] gain_r, gain_nxt;
  logic                     div_start;
  gdiv_stat_t               div_stat;
  logic        [GAIN_W-1:0] div_gain;

  // pipeline registers
  logic                     s1_valid_r, s1_valid_nxt;
  logic        [PIX_W-1:0]  s1_data_r;
  logic                     out_valid_r, out_valid_nxt;
  logic        [PIX_W-1:0]  out_data_r, out_data_nxt;
  logic                     s1_adv;
  logic                     in_acc;

  // register decode; writes beyond the list fall through and are dropped
  always_comb begin
    bright_nxt = bright_r;
    div_start  = 1'b0;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BRIGHTNESS: bright_nxt = $signed(cfg_wdata);
        REG_CONTRAST:   div_start  = 1'b1;
        default:        ;
      endcase
    end
  end

  pbc_gain_div u_gain_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .level ($signed(cfg_wdata)),
    .stat  (div_stat),
    .gain  (div_gain)
  );

  assign gain_nxt = div_stat.done ? div_gain : gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r <= '0;
      gain_r   <= GAIN_ONE;
    end else begin
      bright_r <= bright_nxt;
      gain_r   <= gain_nxt;
    end
  end

  // handshake: stage 1 moves on when the result register is free or drains
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = (!s1_valid_r || s1_adv) && !div_stat.busy;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // channel datapath: alpha passes, r/g/b each adjusted
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (s1_adv) begin
      out_valid_nxt = s1_valid_r;
      out_data_nxt  = {s1_data_r[31:24],
                       adj_chan(s1_data_r[23:16], bright_r, gain_r),
                       adj_chan(s1_data_r[15:8],  bright_r, gain_r),
                       adj_chan(s1_data_r[7:0],   bright_r, gain_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_tdata;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // no pixel enters while the gain is being worked out
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> !in_acc)
    else $error("item accepted while gain divider busy");

  // a contrast write starts the divider
  a_contrast_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == REG_CONTRAST) |=> div_stat.busy)
    else $error("contrast write did not start gain divider");

  // a waiting item in stage 1 is never dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> s1_valid_r)
    else $error("stage 1 item lost under stall");

  // alpha of the moved item reaches the result register unchanged
  a_alpha_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv) |=> (out_valid_r && out_data_r[31:24] == $past(s1_data_r[31:24])))
    else $error("alpha byte altered");

endmodule

// File: verif/pixel_brightness_contrast_unit_tb.sv
// self-checking testbench for pixel_brightness_contrast_unit: directed and random
// argb pixels through the stream ports, checked against an in-bench predictor
// depends on pbc_pkg and the rtl of the unit
`timescale 1ns / 1ps

module pixel_brightness_contrast_unit_tb;
  import pbc_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 5;
  // result register plus input register, with margin
  localparam int PIPE_DRAIN     = 6;
  // the contrast divide and the random gaps on both sides are short
  localparam int STALL_LIMIT    = 2000;
  localparam int IDLE_PERCENT   = 29;
  localparam int PHASES         = 10;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int PRINT_CAP      = 40;

  // register indexes past the end of the list, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [PIX_W-1:0]     in_tdata;   // pixel_in[31:0]
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [PIX_W-1:0]     out_tdata;  // pixel_out[31:0]
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // predictor copy of the register file and the derived gain
  int brightness_now;
  int gain_now;

  logic [PIX_W-1:0] adjusted_pixels_due[$];
  int  mismatch_count = 0;
  int  quiet_cycles   = 0;
  // when set, neither side inserts idle cycles
  bit  steady_flow    = 1'b0;

  pixel_brightness_contrast_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // q2.16 gain, floored: 259*(c+255) / (255*(259-c))
  function automatic int gain_for_level(input logic [CFG_W-1:0] level);
    int     c;
    longint num;
    longint den;
    c   = int'($signed(level));
    num = longint'(K_259 * (c + K_255)) <<< FRAC_W;
    den = longint'(K_255 * (K_259 - c));
    return int'((num / den) & longint'((1 << GAIN_W) - 1));
  endfunction

  function automatic int clamp_byte(input longint v);
    if (v < 0) begin
      return 0;
    end else if (v > 255) begin
      return 255;
    end
    return int'(v);
  endfunction

  // brightness add and clamp, then floor((b-128)*gain)+128 and clamp;
  // the arithmetic shift of a signed product floors toward minus infinity
  function automatic logic [CHAN_W-1:0] shade_channel(input logic [CHAN_W-1:0] ch);
    int     lifted;
    longint prod;
    longint level;
    lifted = clamp_byte(longint'(int'(ch) + brightness_now));
    prod   = longint'(lifted - 128) * longint'(gain_now);
    level  = (prod >>> FRAC_W) + 128;
    return CHAN_W'(clamp_byte(level));
  endfunction

  // alpha passes straight through, colour channels are adjusted
  function automatic logic [PIX_W-1:0] adjust_pixel(input logic [PIX_W-1:0] px);
    return {px[31:24], shade_channel(px[23:16]), shade_channel(px[15:8]),
            shade_channel(px[7:0])};
  endfunction

  // ---------------------------------------------------------------------------
  // shared tasks
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t ns: mismatch: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  // sends one pixel, with random idle cycles in front of it unless steady;
  // in_tvalid stays high after acceptance so back-to-back items need no gap
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    // config only changes while idle, so the prediction can be made here
    adjusted_pixels_due.push_back(adjust_pixel(px));
  endtask

  // drops valid, waits for every result, then lets the pipe run dry
  task automatic settle();
    in_tvalid <= 1'b0;
    while (adjusted_pixels_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // one register write; waits out a running gain divide first (in_tready low)
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    while (!in_tready) begin
      @(posedge clk);
    end
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BRIGHTNESS) begin
      brightness_now = int'($signed(data));
    end else if (idx == REG_CONTRAST) begin
      gain_now = gain_for_level(data);
    end
    @(posedge clk);
  endtask

  // brightness first, so the contrast divide is the last thing started
  task automatic apply_settings(input logic [CFG_W-1:0] bright, input logic [CFG_W-1:0] contrast);
    write_reg(REG_BRIGHTNESS, bright);
    write_reg(REG_CONTRAST, contrast);
  endtask

  // mostly in the documented range, with the 8-bit extremes now and then
  function automatic logic [CFG_W-1:0] pick_setting();
    case ($urandom_range(5))
      0:       return 8'h80;
      1:       return 8'h7F;
      2:       return 8'd0;
      3:       return CFG_W'($urandom_range(255));
      default: return CFG_W'(int'($urandom_range(200)) - 100);
    endcase
  endfunction

  // channels lean towards the clamp and midpoint edges
  function automatic logic [CHAN_W-1:0] pick_channel();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return CHAN_W'($urandom_range(255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // unity gain and zero offset straight out of reset
  task automatic test_reset_state();
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h8080_8080);
    send_pixel(32'h7F7F_7F7F);
    send_pixel(32'h01FE_817E);
    send_pixel(32'h5AA5_C33C);
    settle();
  endtask

  // both registers at the 8-bit limits and at the ends of the usual range
  task automatic test_register_extremes();
    logic [CFG_W-1:0] brights[4];
    logic [CFG_W-1:0] contrasts[4];
    brights   = '{8'h7F, 8'h80, 8'd100, -8'sd100};
    contrasts = '{8'h7F, 8'h80, -8'sd100, 8'd100};
    for (int i = 0; i < 4; i++) begin
      apply_settings(brights[i], contrasts[i]);
      send_pixel(32'hFF00_FF80);
      send_pixel(32'h00FF_7F01);
      send_pixel(32'h8080_8081);
      send_pixel($urandom);
      settle();
    end
  endtask

  // writes to indexes past the list leave the settings alone
  task automatic test_ignored_index();
    apply_settings(8'd37, -8'sd45);
    write_reg(REG_SPARE_2, 8'h7F);
    write_reg(REG_SPARE_3, 8'h80);
    send_pixel(32'h12C8_3FA0);
    send_pixel($urandom);
    settle();
  endtask

  // random settings per phase, random pixels; one phase runs with no idling
  task automatic test_random_traffic();
    logic [PIX_W-1:0] px;
    for (int phase = 0; phase < PHASES; phase++) begin
      case ((phase == 0) ? 2 : $urandom_range(2))
        0:       write_reg(REG_BRIGHTNESS, pick_setting());
        1:       write_reg(REG_CONTRAST, pick_setting());
        default: apply_settings(pick_setting(), pick_setting());
      endcase
      steady_flow = (phase == 4);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        px = {CHAN_W'($urandom_range(255)), pick_channel(), pick_channel(), pick_channel()};
        send_pixel(px);
      end
      settle();
      steady_flow = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure, in-order check
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_tready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin
    logic [PIX_W-1:0] due;
    if (rst_n && out_tvalid && out_tready) begin
      if (adjusted_pixels_due.size() == 0) begin
        report_mismatch($sformatf("pixel %h with nothing outstanding", out_tdata));
      end else begin
        due = adjusted_pixels_due.pop_front();
        if (out_tdata !== due) begin
          report_mismatch($sformatf("pixel_out %h, predicted %h", out_tdata, due));
        end
      end
    end
  end

  // ends a hung run: too long without any item or register write moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no progress, giving up", $realtime);
      $display("pixel_brightness_contrast_unit_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_BRIGHTNESS;
    cfg_wdata <= '0;
    brightness_now = 0;
    gain_now       = int'(GAIN_ONE);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_register_extremes();
    test_ignored_index();
    test_random_traffic();

    settle();
    if (mismatch_count == 0) begin
      $display("pixel_brightness_contrast_unit_tb: done, clean");
    end else begin
      $display("pixel_brightness_contrast_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
